### hdl/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

   localparam int YEAR_WIDTH_DEF = 16;
   localparam int OUT_YEAR_W     = 16;
   localparam int AMT_W          = 16;
   // widest working year: YEAR_WIDTH up to 32, plus one guard bit
   localparam int LEAP_W         = 33;

   localparam logic [1:0] REQ_SET    = 2'd0;
   localparam logic [1:0] REQ_DAYS   = 2'd1;
   localparam logic [1:0] REQ_MONTHS = 2'd2;
   localparam logic [1:0] REQ_YEARS  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [AMT_W-1:0]  new_year;
      logic [3:0]               new_month;
      logic [4:0]               new_day;
      logic signed [AMT_W-1:0]  amount;
   } cda_req_type;

   typedef struct packed {
      logic signed [OUT_YEAR_W-1:0] cur_year;
      logic [3:0]                   cur_month;
      logic [4:0]                   cur_day;
      logic [1:0]                   status;
   } cda_rsp_type;

   typedef struct packed {
      logic load;    // latch request and current date into working regs
      logic leap;    // refresh leap flag of working year
      logic dstep;   // one month-sized step of a day walk
      logic mstep;   // start one month of a month walk
      logic yfix;    // Feb 29 fixup after a year add
      logic commit;  // write back and emit the response
      logic is_set;  // commit checks a set request
   } cda_cmd_type;

   typedef struct packed {
      logic n_zero;  // no days left to walk
      logic k_zero;  // no months left to walk
      logic wrap;    // the pending day step crosses a year end
   } cda_sts_type;

   // Leap test on a signed year. Divisibility by 25 comes from folding the
   // magnitude in 10-bit chunks (1024 is -1 mod 25) and a modular inverse
   // test on the 12-bit remainder.
   function automatic logic leap_of(input logic signed [LEAP_W-1:0] y);
      logic [LEAP_W-1:0] mag;
      logic [11:0]       fold;
      logic [11:0]       prod;
      logic              div4;
      logic              div16;
      logic              div25;
      mag   = y[LEAP_W-1] ? LEAP_W'(-y) : LEAP_W'(y);
      fold  = 12'(mag[9:0]) - 12'(mag[19:10]) + 12'(mag[29:20])
            - 12'(mag[32:30]) + 12'd1050;
      prod  = fold * 12'd3113;
      div25 = (prod <= 12'd163);
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      return div4 && (!div25 || div16);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### hdl/cda_ctrl.sv
`timescale 1ns / 1ps

module cda_ctrl
   import cda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_type,
   input  cda_sts_type sts,
   output cda_cmd_type cmd,
   output logic        busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LEAP   = 3'd1;
   localparam logic [2:0] ST_DSTEP  = 3'd2;
   localparam logic [2:0] ST_MCHK   = 3'd3;
   localparam logic [2:0] ST_YFIX   = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_type;
               state_in = ST_LEAP;
            end
         end
         ST_LEAP: begin
            cmd.leap = 1'b1;
            if (op_ff == REQ_YEARS) begin
               state_in = ST_YFIX;
            end else if (op_ff == REQ_SET) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_DSTEP;
            end
         end
         ST_DSTEP: begin
            if (sts.n_zero) begin
               state_in = (op_ff == REQ_MONTHS) ? ST_MCHK : ST_COMMIT;
            end else begin
               cmd.dstep = 1'b1;
               state_in  = sts.wrap ? ST_LEAP : ST_DSTEP;
            end
         end
         ST_MCHK: begin
            if (sts.k_zero) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.mstep = 1'b1;
               state_in  = ST_DSTEP;
            end
         end
         ST_YFIX: begin
            cmd.yfix = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.is_set = (op_ff == REQ_SET);
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= REQ_SET;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### hdl/cda_datapath.sv
`timescale 1ns / 1ps

module cda_datapath
   import cda_pkg::*;
#(
   parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cda_req_type req_data,
   input  cda_cmd_type cmd,
   output cda_sts_type sts,
   output logic        rsp_valid,
   output cda_rsp_type rsp_data
);

   localparam int CALC_W = ((YEAR_WIDTH > AMT_W) ? YEAR_WIDTH : AMT_W) + 1;
   localparam int CNT_W  = AMT_W + 1;
   localparam logic signed [CALC_W-1:0] YEAR_MAX =
      CALC_W'((longint'(1) << (YEAR_WIDTH - 1)) - longint'(1));
   localparam logic signed [CALC_W-1:0] YEAR_MIN = -YEAR_MAX - CALC_W'(1);
   localparam logic signed [YEAR_WIDTH-1:0] YEAR_RESET = YEAR_WIDTH'(2001);

   // stored date
   logic signed [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [3:0]                   month_ff, month_in;
   logic [4:0]                   day_ff, day_in;

   // working date and counters
   logic signed [CALC_W-1:0] y_ff, y_in;
   logic [3:0]               m_ff, m_in;
   logic [4:0]               d_ff, d_in;
   logic signed [CNT_W-1:0]  n_ff, n_in;
   logic signed [CNT_W-1:0]  k_ff, k_in;
   logic signed [AMT_W-1:0]  amt_ff, amt_in;
   logic                     leap_ff, leap_in;

   logic        rsp_valid_ff;
   cda_rsp_type rsp_ff, rsp_in;

   logic [4:0]              len_cur, len_prev;
   logic [3:0]              prev_m;
   logic signed [CNT_W-1:0] d_s, len_s, fwd_diff, bwd_sum;
   logic                    fwd, fwd_fit, bwd_fit;
   logic                    range_bad, set_bad, ok;
   logic [1:0]              status;

   assign len_cur  = month_len(m_ff, leap_ff);
   assign prev_m   = (m_ff == MONTH_JAN) ? MONTH_DEC : m_ff - 4'd1;
   assign len_prev = month_len(prev_m, leap_ff);
   assign d_s      = CNT_W'(d_ff);
   assign len_s    = CNT_W'(len_cur);
   assign fwd      = !n_ff[CNT_W-1] && (n_ff != '0);
   assign fwd_diff = n_ff - len_s + d_s - CNT_W'(1);
   assign fwd_fit  = fwd_diff[CNT_W-1];
   assign bwd_sum  = n_ff + d_s;
   assign bwd_fit  = !bwd_sum[CNT_W-1] && (bwd_sum != '0);

   assign sts.n_zero = (n_ff == '0);
   assign sts.k_zero = (k_ff == '0);
   assign sts.wrap   = fwd ? (!fwd_fit && m_ff == MONTH_DEC)
                           : (!bwd_fit && m_ff == MONTH_JAN);

   assign range_bad = (y_ff < YEAR_MIN) || (y_ff > YEAR_MAX);
   assign set_bad   = range_bad || (m_ff < MONTH_JAN) || (m_ff > MONTH_DEC)
                   || (d_ff == 5'd0) || (d_ff > len_cur);
   always_comb begin
      if (cmd.is_set) begin
         status = set_bad ? STATUS_INVALID : STATUS_OK;
      end else begin
         status = range_bad ? STATUS_OVERFLOW : STATUS_OK;
      end
   end
   assign ok = (status == STATUS_OK);

   always_comb begin
      y_in     = y_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      amt_in   = amt_ff;
      leap_in  = leap_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         amt_in = req_data.amount;
         k_in   = CNT_W'(req_data.amount);
         n_in   = (req_data.req_type == REQ_DAYS) ? CNT_W'(req_data.amount) : '0;
         if (req_data.req_type == REQ_SET) begin
            y_in = CALC_W'(req_data.new_year);
            m_in = req_data.new_month;
            d_in = req_data.new_day;
         end else begin
            y_in = CALC_W'(year_ff);
            if (req_data.req_type == REQ_YEARS) begin
               y_in = CALC_W'(year_ff) + CALC_W'(req_data.amount);
            end
            m_in = month_ff;
            d_in = day_ff;
         end
      end
      if (cmd.leap) begin
         leap_in = leap_of(LEAP_W'(y_ff));
      end
      if (cmd.dstep) begin
         if (fwd) begin
            if (fwd_fit) begin
               d_in = d_ff + n_ff[4:0];
               n_in = '0;
            end else begin
               n_in = fwd_diff;
               d_in = 5'd1;
               if (m_ff == MONTH_DEC) begin
                  m_in = MONTH_JAN;
                  y_in = y_ff + CALC_W'(1);
               end else begin
                  m_in = m_ff + 4'd1;
               end
            end
         end else begin
            if (bwd_fit) begin
               d_in = bwd_sum[4:0];
               n_in = '0;
            end else begin
               n_in = bwd_sum;
               m_in = prev_m;
               d_in = len_prev;
               if (m_ff == MONTH_JAN) begin
                  y_in = y_ff - CALC_W'(1);
               end
            end
         end
      end
      if (cmd.mstep) begin
         if (!k_ff[CNT_W-1]) begin
            n_in = len_s;
            k_in = k_ff - CNT_W'(1);
         end else begin
            n_in = -len_s;
            k_in = k_ff + CNT_W'(1);
         end
      end
      if (cmd.yfix) begin
         if (m_ff == MONTH_FEB && d_ff == 5'd29 && !leap_ff) begin
            if (!amt_ff[AMT_W-1] && amt_ff != '0) begin
               m_in = MONTH_MAR;
               d_in = 5'd1;
            end else if (amt_ff[AMT_W-1]) begin
               d_in = 5'd28;
            end
         end
      end
      if (cmd.commit) begin
         if (ok) begin
            year_in  = y_ff[YEAR_WIDTH-1:0];
            month_in = m_ff;
            day_in   = d_ff;
            rsp_in.cur_year  = OUT_YEAR_W'(y_ff);
            rsp_in.cur_month = m_ff;
            rsp_in.cur_day   = d_ff;
         end else begin
            rsp_in.cur_year  = OUT_YEAR_W'(year_ff);
            rsp_in.cur_month = month_ff;
            rsp_in.cur_day   = day_ff;
         end
         rsp_in.status = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff      <= YEAR_RESET;
         month_ff     <= MONTH_JAN;
         day_ff       <= 5'd1;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
      end else begin
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         rsp_valid_ff <= cmd.commit;
         n_ff         <= n_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      m_ff    <= m_in;
      d_ff    <= d_in;
      amt_ff  <= amt_in;
      leap_ff <= leap_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/calendar_date_adder_top.sv
`timescale 1ns / 1ps

// Gregorian date register with set-date, add-days, add-months and add-years
// requests. A request is taken when start is high and busy is low; exactly
// one response follows on rsp_valid/rsp_data, held for a single cycle, and
// the receiver cannot stall it. A new request may be issued while that
// response is on the bus. Set date passes the leap-flag refresh and the
// commit; add years passes the leap-flag refresh, the Feb 29 fixup and the
// commit. Add days walks the date in day steps, each crossing at most one
// month boundary, with a leap-flag refresh after each year boundary crossed.
// Add months runs, for each month asked for, a check, a setup step and day
// steps, with a leap-flag refresh after each year boundary crossed, and a
// final check. The control state machine sequences the walk and the
// datapath performs each step. A rejected set (status 1) or a year overflow
// (status 2) leaves the stored date as it was.

module calendar_date_adder_top
   import cda_pkg::*;
#(
   parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  cda_req_type req_data,
   output logic        rsp_valid,
   output cda_rsp_type rsp_data
);

   cda_cmd_type cmd;
   cda_sts_type sts;

   // sequencer: one state per phase of a request
   cda_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // date registers, working date, walk counters and response register
   cda_datapath #(
      .YEAR_WIDTH (YEAR_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a response only follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without work");

   // a response always carries a month in range and a nonzero day
   a_rsp_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_month >= MONTH_JAN && rsp_data.cur_month <= MONTH_DEC
                     && rsp_data.cur_day != 5'd0))
      else $error("response date out of range");

   // status is one of the three defined codes
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_INVALID
                     || rsp_data.status == STATUS_OVERFLOW))
      else $error("undefined response status");

endmodule
